// ===== rtl/assert_macros.svh =====
// assertion helpers for the deque checker
// both expect i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;
    localparam int OUT_CNT_W   = 5;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_UPDATE = 2'd1,
        S_READ   = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch_item;
        logic update;
        logic load_out;
    } t_dp_cmd;

    // base + off modulo CAPACITY, both operands below CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/dq_ram.sv =====
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/dq_ctrl.sv =====
`timescale 1ns / 1ps

module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output dq_pkg::t_dp_cmd o_cmd
);

    import dq_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    in_accept;
    logic    out_free;

    assign in_accept = i_valid && (r_state == S_IDLE);
    // output register empty or emptied this cycle
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = S_READ;
            S_READ:   n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.latch_item = in_accept;
        case (r_state)
            S_UPDATE: o_cmd.update   = 1'b1;
            S_FINISH: o_cmd.load_out = out_free;
            default:  o_cmd.update   = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/dq_datapath.sv =====
`timescale 1ns / 1ps

module dq_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dq_pkg::t_dp_cmd                i_cmd,
    input  logic [dq_pkg::OP_W-1:0]        i_operation,
    input  logic [dq_pkg::VAL_W-1:0]       i_push_value,
    output logic [dq_pkg::VAL_W-1:0]       o_popped_value,
    output logic [dq_pkg::VAL_W-1:0]       o_front_value,
    output logic [dq_pkg::VAL_W-1:0]       o_back_value,
    output logic [dq_pkg::OUT_CNT_W-1:0]   o_entry_count,
    output logic [dq_pkg::STATUS_W-1:0]    o_status
);

    import dq_pkg::*;

    // item registers
    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_val;

    // queue pointers
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      n_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    // per-item results held until the output load
    logic [DATA_WIDTH-1:0] r_popped;
    logic [DATA_WIDTH-1:0] n_popped;
    t_status               r_status;
    t_status               n_status;

    // output registers
    logic [VAL_W-1:0]      r_out_popped;
    logic [VAL_W-1:0]      r_out_front;
    logic [VAL_W-1:0]      r_out_back;
    logic [OUT_CNT_W-1:0]  r_out_count;
    t_status               r_out_status;

    // store access
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      back_off;
    logic [IDX_W-1:0]      back_idx;
    logic [CNT_W-1:0]      count_m1;
    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;
    logic                  is_empty;
    logic                  is_full;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign count_m1 = r_count - CNT_W'(1);
    assign back_off = is_empty ? '0 : count_m1[IDX_W-1:0];
    assign back_idx = ring_add(r_head, back_off);

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_dq_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (r_val),
        .i_rd_addr_a (r_head),
        .o_rd_data_a (front_data),
        .i_rd_addr_b (back_idx),
        .o_rd_data_b (back_data)
    );

    // read data during update is the old front and back
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_popped = '0;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = ring_add(r_head, r_count[IDX_W-1:0]);
        case (r_op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = ring_add(r_head, IDX_W'(CAPACITY - 1));
                    wr_addr = n_head;
                    wr_en   = i_cmd.update;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = i_cmd.update;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = front_data;
                    n_head   = ring_add(r_head, IDX_W'(1));
                    n_count  = count_m1;
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = back_data;
                    n_count  = count_m1;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_op  <= t_op'(i_operation);
            r_val <= DATA_WIDTH'(i_push_value);
        end
        if (i_cmd.update) begin
            r_popped <= n_popped;
            r_status <= n_status;
        end
        // read data now reflects the new front and back
        if (i_cmd.load_out) begin
            r_out_popped <= VAL_W'(r_popped);
            r_out_front  <= is_empty ? '0 : VAL_W'(front_data);
            r_out_back   <= is_empty ? '0 : VAL_W'(back_data);
            r_out_count  <= OUT_CNT_W'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_popped_value = r_out_popped;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_entry_count  = r_out_count;
    assign o_status       = r_out_status;

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps

// double-ended queue of sixteen 32-bit entries kept in a ring memory with a
// head pointer and an entry count. each input item is one operation: push
// front, push back, pop front, pop back or clear (undefined codes do nothing).
// every item gives exactly one result item: the popped value (zero unless a
// pop succeeded), the front and back values after the operation (zero when
// empty), the entry count after the operation, and a status (ok, pop on empty,
// push on full). a failed push or pop leaves the queue untouched. one item
// is in work at a time. the old front and back are read from the store while
// the block waits for an item, so after acceptance the sequencer updates the
// pointers and writes the store, then re-reads the new front and back through
// the store's two registered read ports, then loads the result register. the
// input is taken again as soon as the result is loaded, even if that result
// still sits stalled in the output register; a stalled output holds the
// sequencer in its last step. there is no clearing pass after reset
module double_ended_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // operation items
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dq_pkg::OP_W-1:0]       i_operation,
    input  logic [dq_pkg::VAL_W-1:0]      i_push_value,
    // result items
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dq_pkg::VAL_W-1:0]      o_popped_value,
    output logic [dq_pkg::VAL_W-1:0]      o_front_value,
    output logic [dq_pkg::VAL_W-1:0]      o_back_value,
    output logic [dq_pkg::OUT_CNT_W-1:0]  o_entry_count,
    output logic [dq_pkg::STATUS_W-1:0]   o_status
);

    import dq_pkg::*;

    // sequencing commands from the controller
    t_dp_cmd dp_cmd;

    // controller: accept, update, re-read, then load the output register
    dq_ctrl u_dq_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd)
    );

    // datapath: head/count pointers, ring memory and result registers
    dq_datapath u_dq_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

endmodule

// ===== rtl/dq_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [dq_pkg::OP_W-1:0]       i_operation,
    input logic [dq_pkg::VAL_W-1:0]      i_push_value,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [dq_pkg::VAL_W-1:0]      o_popped_value,
    input logic [dq_pkg::VAL_W-1:0]      o_front_value,
    input logic [dq_pkg::VAL_W-1:0]      o_back_value,
    input logic [dq_pkg::OUT_CNT_W-1:0]  o_entry_count,
    input logic [dq_pkg::STATUS_W-1:0]   o_status
);

    import dq_pkg::*;

    // whole result item as one vector
    logic [3*VAL_W+OUT_CNT_W+STATUS_W-1:0] out_view;
    logic                                  status_err;
    logic                                  err_consistent;
    logic                                  out_empty;
    logic                                  ends_zero;

    assign out_view       = {o_popped_value, o_front_value, o_back_value,
                             o_entry_count, o_status};
    assign status_err     = (o_status != ST_OK);
    assign err_consistent = (o_status == ST_EMPTY && o_entry_count == '0)
                         || (o_status == ST_FULL && o_entry_count == OUT_CNT_W'(CAPACITY));
    assign out_empty      = (o_entry_count == '0);
    assign ends_zero      = (o_front_value == '0) && (o_back_value == '0);

    // one item at a time: the input closes right after an accept
    `DQ_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input open after accept")

    // a stalled result holds
    `DQ_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_view), "result not held")

    `DQ_ASSERT_NOW(a_count_range, o_valid, o_entry_count <= OUT_CNT_W'(CAPACITY), "count too high")

    `DQ_ASSERT_NOW(a_status_count, o_valid && status_err, err_consistent, "bad error status")

    `DQ_ASSERT_NOW(a_empty_zero, o_valid && out_empty, ends_zero, "nonzero ends when empty")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// checks double_ended_queue against a behavioral deque kept inside the bench.
// every accepted operation updates that deque and queues the expected result
// item; a monitor on the output side compares each accepted result item field
// by field with the oldest queued one. stimulus covers corner cases first,
// then a forced wraparound fill and drain, then long random runs biased to
// grow or shrink the queue or balanced between the two, then a long receiver
// hold-off with back-to-back input to fill the pipeline
module testbench;
    import dq_pkg::*;

    // operation codes the block treats as no operation
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
    // stored bits of a pushed value
    localparam logic [VAL_W-1:0] DATA_MASK = VAL_W'((64'd1 << DATA_WIDTH) - 64'd1);
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS = 50;
    // slots of the expected-result ring, far above what can be in flight
    localparam int OWED_SLOTS = 64;

    typedef struct packed {
        logic [VAL_W-1:0]     popped;
        logic [VAL_W-1:0]     front;
        logic [VAL_W-1:0]     back;
        logic [OUT_CNT_W-1:0] count;
        t_status              status;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_W-1:0]      i_operation;
    logic [VAL_W-1:0]     i_push_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [VAL_W-1:0]     o_popped_value;
    logic [VAL_W-1:0]     o_front_value;
    logic [VAL_W-1:0]     o_back_value;
    logic [OUT_CNT_W-1:0] o_entry_count;
    logic [STATUS_W-1:0]  o_status;

    // behavioral deque: ring of entries, head position and element count
    logic [VAL_W-1:0] deque_ring [CAPACITY];
    int               deque_head;
    int               deque_count;

    // results still owed by the block, oldest first, in a ring
    t_result owed_results [OWED_SLOTS];
    int      owed_wr;
    int      owed_rd;

    int items_sent;
    int results_checked;
    int error_count;
    int full_pushes;
    int empty_pops;
    int clears_seen;

    // traffic shaping shared by sender and receiver
    bit quiet_mode;       // no gaps, and no stalls beyond a counted hold-off
    int hold_off_cycles;  // receiver holds stall high for this many cycles

    double_ended_queue u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // number of result items still owed
    function automatic int owed_count();
        return owed_wr - owed_rd;
    endfunction

    // gap or stall run length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // applies one operation to the behavioral deque and returns its result
    function automatic t_result deque_apply(input logic [OP_W-1:0] op,
                                            input logic [VAL_W-1:0] value);
        t_result r;
        int      tail;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (deque_count >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_pushes++;
                end else if (op == OP_PUSH_FRONT) begin
                    deque_head = (deque_head + CAPACITY - 1) % CAPACITY;
                    deque_ring[deque_head] = value & DATA_MASK;
                    deque_count++;
                end else begin
                    deque_ring[(deque_head + deque_count) % CAPACITY] = value & DATA_MASK;
                    deque_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                    empty_pops++;
                end else if (op == OP_POP_FRONT) begin
                    r.popped = deque_ring[deque_head];
                    deque_head = (deque_head + 1) % CAPACITY;
                    deque_count--;
                end else begin
                    r.popped = deque_ring[(deque_head + deque_count - 1) % CAPACITY];
                    deque_count--;
                end
            end
            OP_CLEAR: begin
                deque_count = 0;
                deque_head = 0;
                clears_seen++;
            end
            default: ;  // undefined codes leave the deque alone
        endcase
        if (deque_count != 0) begin
            tail = (deque_head + deque_count - 1) % CAPACITY;
            r.front = deque_ring[deque_head];
            r.back = deque_ring[tail];
        end
        r.count = OUT_CNT_W'(deque_count);
        return r;
    endfunction

    // offers one item after a random gap and waits until the block takes it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation = op;
        i_push_value = value;
        i_valid = 1'b1;
        // the handshake is sampled with the values before the edge
        do @(posedge i_clk); while (o_stall);
        owed_results[owed_wr % OWED_SLOTS] = deque_apply(op, value);
        owed_wr++;
        items_sent++;
    endtask

    // sender stops and waits until every owed result item has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (owed_count() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 16) begin
            return '1;
        end
        return $urandom;
    endfunction

    // random operation with the given share of pushes, rest mostly pops
    function automatic logic [OP_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return OP_CLEAR;
        end else if (r < 6) begin
            return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end else if (r < 6 + push_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // empty pops, undefined codes, extreme values, clear with entries present
    task automatic test_corners();
        logic [OP_W-1:0] op;
        send_item(OP_POP_FRONT, '1);
        send_item(OP_POP_BACK, '0);
        for (op = OP_UNDEF_LO; op <= OP_UNDEF_HI && op >= OP_UNDEF_LO; op++) begin
            send_item(op, '1);
        end
        send_item(OP_PUSH_FRONT, '1);
        send_item(OP_PUSH_BACK, '0);
        send_item(OP_PUSH_BACK, 32'h8000_0001);
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFE);
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_CLEAR, '1);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_PUSH_BACK, 32'h5A5A_A5A5);
        send_item(OP_POP_BACK, '0);
        wait_drain();
    endtask

    // moves the head off zero, fills through the wrap, hits full, drains to empty
    task automatic test_wraparound();
        repeat (5) send_item(OP_PUSH_BACK, pick_value());
        repeat (5) send_item(OP_POP_FRONT, pick_value());
        while (deque_count < CAPACITY) begin
            send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        end
        send_item(OP_PUSH_FRONT, pick_value());
        send_item(OP_PUSH_BACK, pick_value());
        while (deque_count > 0) begin
            send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_value());
        end
        send_item(OP_POP_BACK, pick_value());
        wait_drain();
    endtask

    // phases alternate between growing, shrinking and balanced traffic so the
    // queue spends time both full and empty; some phases run with no idling
    task automatic test_random_traffic();
        int push_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 3)
                0: push_pct = 70;
                1: push_pct = 20;
                default: push_pct = 47;
            endcase
            quiet_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_op(push_pct), pick_value());
            end
            // sometimes let the block go completely idle between phases
            if ($urandom_range(0, 2) == 0) begin
                wait_drain();
            end
        end
        quiet_mode = 1'b0;
        wait_drain();
    endtask

    // long receiver hold-off while the sender keeps offering back to back,
    // so the result register fills and the input side stalls
    task automatic test_backpressure();
        quiet_mode = 1'b1;
        @(negedge i_clk);
        hold_off_cycles = 80;
        repeat (30) send_item(pick_op(50), pick_value());
        quiet_mode = 1'b0;
        wait_drain();
    endtask

    // receiver: stall runs of random length, or a counted hold-off
    initial begin
        int stall_run;
        stall_run = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_stall = 1'b1;
                hold_off_cycles--;
            end else if (quiet_mode) begin
                i_stall = 1'b0;
                stall_run = 0;
            end else if (stall_run > 0) begin
                i_stall = 1'b1;
                stall_run--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_run = pick_gap();
                i_stall = (stall_run > 0);
                if (stall_run > 0) begin
                    stall_run--;
                end
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result monitor: every accepted result item against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (owed_count() == 0) begin
                $display("%0t: unexpected result item, count %0d status %0d",
                         $time, o_entry_count, o_status);
                error_count++;
            end else begin
                want = owed_results[owed_rd % OWED_SLOTS];
                owed_rd++;
                check_field("popped_value", want.popped, o_popped_value);
                check_field("front_value", want.front, o_front_value);
                check_field("back_value", want.back, o_back_value);
                check_field("entry_count", VAL_W'(want.count), VAL_W'(o_entry_count));
                check_field("status", VAL_W'(want.status), VAL_W'(o_status));
                results_checked++;
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d result items outstanding",
                 $time, owed_count());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_CLEAR;
        i_push_value = '0;
        quiet_mode = 1'b0;
        hold_off_cycles = 0;
        owed_wr = 0;
        owed_rd = 0;
        items_sent = 0;
        results_checked = 0;
        error_count = 0;
        full_pushes = 0;
        empty_pops = 0;
        clears_seen = 0;
        deque_head = 0;
        deque_count = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            deque_ring[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corners();
        test_wraparound();
        test_random_traffic();
        test_backpressure();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (owed_count() != 0) begin
            $display("%0t: %0d result items never arrived", $time, owed_count());
            error_count++;
        end

        $display("ran %0d operations, checked %0d result items, %0d errors",
                 items_sent, results_checked, error_count);
        $display("pushes on full %0d, pops on empty %0d, clears %0d",
                 full_pushes, empty_pops, clears_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue.f =====
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
bench/testbench.sv
